// File: design/mexp_pkg.sv
package mexp_pkg;

    localparam int MEXP_OPERAND_BITS = 31;

    // controller to datapath
    typedef struct packed {
        logic load;       // take a new item from the input transfer
        logic mul_sq;     // product of accumulator with itself
        logic mul_b;      // product of accumulator and base
        logic red_step;   // one remainder step of the product
        logic exp_shift;  // move to the next exponent bit
        logic out_load;   // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic exp_msb;    // current exponent bit
        logic exp_last;   // current bit is the last one
        logic red_last;   // remainder step in progress is the last one
        logic out_free;   // output register can take a result this cycle
    } t_dp_sts;

endpackage

// File: design/modular_exponentiation_top.sv
// each 2W-bit product, W = OPERAND_BITS, is reduced by one bit-serial remainder step per cycle;
// one item at a time: a new input is taken only while the controller is idle
// the next input is taken while a finished result still waits in the output register
// synchronous active-low reset clears the controller and the output valid flag
module modular_exponentiation_top #(
    parameter int OPERAND_BITS = mexp_pkg::MEXP_OPERAND_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // base, exponent, modulus, zero fill
    input  logic [((3*OPERAND_BITS+7)/8)*8-1:0]    i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // power_mod, zero fill
    output logic [((OPERAND_BITS+7)/8)*8-1:0]      o_m_tdata
);
    import mexp_pkg::*;

    localparam int W    = OPERAND_BITS;
    localparam int OTDW = ((W + 7) / 8) * 8;

    t_dp_cmd      cmd;
    t_dp_sts      sts;
    logic [W-1:0] power_mod;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mexp_dp #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (i_s_tdata[W-1:0]),
        .i_exponent  (i_s_tdata[2*W-1:W]),
        .i_modulus   (i_s_tdata[3*W-1:2*W]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_power_mod (power_mod)
    );

    assign o_m_tdata = OTDW'(power_mod);

endmodule

// File: design/mexp_ctrl.sv
module mexp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mexp_pkg::t_dp_sts  i_sts,
    output mexp_pkg::t_dp_cmd  o_cmd
);
    import mexp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQR  = 6'b000010,
        S_RSQ  = 6'b000100,
        S_MULB = 6'b001000,
        S_RMB  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = S_RSQ;
            end
            S_RSQ: begin
                o_cmd.red_step = 1'b1;
                if (i_sts.red_last) begin
                    if (i_sts.exp_msb) begin
                        n_state = S_MULB;
                    end else if (i_sts.exp_last) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.exp_shift = 1'b1;
                        n_state         = S_SQR;
                    end
                end
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_RMB;
            end
            S_RMB: begin
                o_cmd.red_step = 1'b1;
                if (i_sts.red_last) begin
                    if (i_sts.exp_last) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.exp_shift = 1'b1;
                        n_state         = S_SQR;
                    end
                end
            end
            S_OUT: begin
                // wait until the previous result has been taken
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/mexp_dp.sv
module mexp_dp #(
    parameter int OPERAND_BITS = mexp_pkg::MEXP_OPERAND_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [OPERAND_BITS-1:0] i_base,
    input  logic [OPERAND_BITS-1:0] i_exponent,
    input  logic [OPERAND_BITS-1:0] i_modulus,
    input  mexp_pkg::t_dp_cmd       i_cmd,
    output mexp_pkg::t_dp_sts       o_sts,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [OPERAND_BITS-1:0] o_power_mod
);
    import mexp_pkg::*;

    localparam int W   = OPERAND_BITS;
    localparam int PW  = 2 * W;
    localparam int ECW = $clog2(W);
    localparam int RCW = $clog2(PW);

    logic [W-1:0]   r_base;
    logic [W-1:0]   r_exp;
    logic [W-1:0]   r_mod;
    logic [W-1:0]   r_acc;
    logic [PW-1:0]  r_prod;
    logic [W-1:0]   r_rem;
    logic [ECW-1:0] r_expcnt;
    logic [RCW-1:0] r_redcnt;
    logic           r_out_valid;
    logic [W-1:0]   r_out;

    logic [W-1:0]   mul_b;
    logic [W:0]     rem_sh;
    logic [W-1:0]   n_rem;

    assign mul_b = i_cmd.mul_b ? r_base : r_acc;

    // restoring remainder step, one product bit per cycle
    assign rem_sh = {r_rem, r_prod[PW-1]};
    always_comb begin
        if (rem_sh >= {1'b0, r_mod}) begin
            n_rem = W'(rem_sh - {1'b0, r_mod});
        end else begin
            n_rem = rem_sh[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base   <= i_base;
            r_exp    <= i_exponent;
            r_mod    <= i_modulus;
            r_acc    <= (i_modulus == W'(1)) ? '0 : W'(1);
            r_expcnt <= '0;
        end
        if (i_cmd.mul_sq || i_cmd.mul_b) begin
            r_prod   <= PW'(r_acc) * PW'(mul_b);
            r_rem    <= '0;
            r_redcnt <= '0;
        end
        if (i_cmd.red_step) begin
            r_prod   <= {r_prod[PW-2:0], 1'b0};
            r_rem    <= n_rem;
            r_redcnt <= r_redcnt + RCW'(1);
            if (o_sts.red_last) begin
                r_acc <= n_rem;
            end
        end
        if (i_cmd.exp_shift) begin
            r_exp    <= {r_exp[W-2:0], 1'b0};
            r_expcnt <= r_expcnt + ECW'(1);
        end
        if (i_cmd.out_load) begin
            // no reduction is possible with a zero modulus
            r_out <= (r_mod == '0) ? '0 : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.exp_msb  = r_exp[W-1];
    assign o_sts.exp_last = (r_expcnt == ECW'(W - 1));
    assign o_sts.red_last = (r_redcnt == RCW'(PW - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_power_mod = r_out;

endmodule
